// ===== rtl/mplr_pkg.sv =====
// ----------------------------------------------------------------------------
// Midpoint line rasterizer package
// Shared transaction types, opcodes and sizing constants for the line engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mplr_pkg;

    localparam int COORD_BITS_DEFAULT = 12;
    localparam int PIX_W              = 12;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [PIX_W-1:0] x_start;
        logic [PIX_W-1:0] y_start;
        logic [PIX_W-1:0] x_end;
        logic [PIX_W-1:0] y_end;
    } mplr_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
        logic             last_pixel;
    } mplr_out_t;

endpackage

`default_nettype wire

// ===== rtl/midpoint_line_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// Midpoint line rasterizer core
// Loads two endpoints with a start transaction and emits one pixel of the
// line for each step transaction, flagging the final pixel.
// ----------------------------------------------------------------------------
// The core takes one transaction per clock while in_stall is low, and registers
// a step's pixel into its output buffer; the decision update is a single add and compare
// between the line state registers and the result register. A two-entry
// output buffer lets input keep flowing while one pixel waits downstream, so
// in_stall rises only when both entries are full.
`default_nettype none

module midpoint_line_rasterizer_core #(
    parameter int COORD_BITS = mplr_pkg::COORD_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  mplr_pkg::mplr_in_t in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output mplr_pkg::mplr_out_t out_data
);
    import mplr_pkg::*;

    localparam int DEC_W = COORD_BITS + 3;
    localparam int STR_W = COORD_BITS + 2;

    typedef enum logic [2:0] {
        MODE_HORIZ,
        MODE_VERT,
        MODE_SHALLOW_POS,
        MODE_STEEP_POS,
        MODE_SHALLOW_NEG,
        MODE_STEEP_NEG,
        MODE_DIAG_RISE,
        MODE_DIAG_FALL
    } line_mode_t;

    logic [COORD_BITS-1:0]   cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]   cur_y_reg, cur_y_next;
    logic signed [DEC_W-1:0] decision_reg, decision_next;
    logic [STR_W-1:0]        inc_str_reg, inc_str_next;
    logic signed [DEC_W-1:0] inc_diag_reg, inc_diag_next;
    logic [COORD_BITS-1:0]   major_end_reg, major_end_next;
    line_mode_t              mode_reg, mode_next;
    logic                    active_reg, active_next;
    logic                    first_reg, first_next;

    logic                    out_valid_reg;
    mplr_out_t               out_data_reg;
    logic                    skid_valid_reg;
    mplr_out_t               skid_data_reg;

    logic                    in_fire;
    logic                    out_fire;
    logic                    out_free;
    logic                    res_valid;
    mplr_out_t               res_data;

    logic [COORD_BITS-1:0]   xa, ya, xb, yb;
    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS-1:0]   adx, ady;
    logic [COORD_BITS-1:0]   min_x, max_x, min_y, max_y;
    logic [COORD_BITS-1:0]   minor_len, major_len;
    logic signed [DEC_W-1:0] ld_dec, ld_diag;
    logic [STR_W-1:0]        ld_str;

    logic                    dec_pos;
    logic signed [DEC_W-1:0] dec_straight, dec_diag;
    logic [COORD_BITS-1:0]   adv_x, adv_y;
    logic signed [DEC_W-1:0] adv_dec;
    logic [COORD_BITS-1:0]   step_x, step_y, step_major;
    logic signed [DEC_W-1:0] step_dec;
    logic                    step_last;

    assign in_fire   = in_valid && !in_stall;
    assign in_stall  = skid_valid_reg;
    assign out_fire  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        xa = COORD_BITS'(in_data.x_start);
        ya = COORD_BITS'(in_data.y_start);
        xb = COORD_BITS'(in_data.x_end);
        yb = COORD_BITS'(in_data.y_end);
        dx = $signed({1'b0, xb}) - $signed({1'b0, xa});
        dy = $signed({1'b0, yb}) - $signed({1'b0, ya});
        adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
        ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
        min_x = (xa < xb) ? xa : xb;
        max_x = (xa < xb) ? xb : xa;
        min_y = (ya < yb) ? ya : yb;
        max_y = (ya < yb) ? yb : ya;
        minor_len = (ady < adx) ? ady : adx;
        major_len = (ady < adx) ? adx : ady;
        ld_dec  = DEC_W'({minor_len, 1'b0}) - DEC_W'(major_len);
        ld_str  = STR_W'({minor_len, 1'b0});
        ld_diag = DEC_W'({minor_len, 1'b0}) - DEC_W'({major_len, 1'b0});
    end

    always_comb
    begin
        dec_pos      = !decision_reg[DEC_W-1] && (decision_reg != '0);
        dec_straight = decision_reg + DEC_W'(inc_str_reg);
        dec_diag     = decision_reg + inc_diag_reg;
        adv_x        = cur_x_reg;
        adv_y        = cur_y_reg;
        adv_dec      = decision_reg;
        case (mode_reg)
            MODE_HORIZ:
            begin
                adv_x = cur_x_reg + COORD_BITS'(1);
            end
            MODE_VERT:
            begin
                adv_y = cur_y_reg + COORD_BITS'(1);
            end
            MODE_SHALLOW_POS, MODE_SHALLOW_NEG:
            begin
                adv_x = cur_x_reg + COORD_BITS'(1);
                if (dec_pos)
                begin
                    adv_dec = dec_diag;
                    adv_y   = (mode_reg == MODE_SHALLOW_POS) ? cur_y_reg + COORD_BITS'(1)
                                                             : cur_y_reg - COORD_BITS'(1);
                end
                else
                begin
                    adv_dec = dec_straight;
                end
            end
            MODE_STEEP_POS, MODE_STEEP_NEG:
            begin
                adv_y = cur_y_reg + COORD_BITS'(1);
                if (dec_pos)
                begin
                    adv_dec = dec_diag;
                    adv_x   = (mode_reg == MODE_STEEP_POS) ? cur_x_reg + COORD_BITS'(1)
                                                           : cur_x_reg - COORD_BITS'(1);
                end
                else
                begin
                    adv_dec = dec_straight;
                end
            end
            MODE_DIAG_RISE, MODE_DIAG_FALL:
            begin
                adv_x = (mode_reg == MODE_DIAG_RISE) ? cur_x_reg + COORD_BITS'(1)
                                                     : cur_x_reg - COORD_BITS'(1);
                adv_y = inc_str_reg[0] ? cur_y_reg - COORD_BITS'(1)
                                       : cur_y_reg + COORD_BITS'(1);
            end
            default:
            begin
                adv_x = cur_x_reg;
            end
        endcase

        step_x   = first_reg ? cur_x_reg : adv_x;
        step_y   = first_reg ? cur_y_reg : adv_y;
        step_dec = first_reg ? decision_reg : adv_dec;
        step_major = (mode_reg == MODE_VERT || mode_reg == MODE_STEEP_POS ||
                      mode_reg == MODE_STEEP_NEG) ? step_y : step_x;
        step_last  = (step_major == major_end_reg);

        res_valid           = in_fire && (in_data.opcode == OP_STEP) && active_reg;
        res_data.pixel_x    = PIX_W'(step_x);
        res_data.pixel_y    = PIX_W'(step_y);
        res_data.last_pixel = step_last;
    end

    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        decision_next  = decision_reg;
        inc_str_next   = inc_str_reg;
        inc_diag_next  = inc_diag_reg;
        major_end_next = major_end_reg;
        mode_next      = mode_reg;
        active_next    = active_reg;
        first_next     = first_reg;
        if (in_fire && in_data.opcode == OP_START)
        begin
            decision_next = '0;
            inc_str_next  = '0;
            inc_diag_next = '0;
            active_next   = 1'b1;
            first_next    = 1'b1;
            if (dy == '0)
            begin
                mode_next      = MODE_HORIZ;
                cur_x_next     = min_x;
                cur_y_next     = ya;
                major_end_next = max_x;
            end
            else if (dx == '0)
            begin
                mode_next      = MODE_VERT;
                cur_x_next     = xa;
                cur_y_next     = min_y;
                major_end_next = max_y;
            end
            else if (adx == ady)
            begin
                mode_next      = dx[COORD_BITS] ? MODE_DIAG_FALL : MODE_DIAG_RISE;
                inc_str_next   = STR_W'(dy[COORD_BITS]);
                cur_x_next     = xa;
                cur_y_next     = ya;
                major_end_next = xb;
            end
            else
            begin
                decision_next = ld_dec;
                inc_str_next  = ld_str;
                inc_diag_next = ld_diag;
                if (dx[COORD_BITS] == dy[COORD_BITS])
                begin
                    cur_x_next = min_x;
                    cur_y_next = min_y;
                    if (ady < adx)
                    begin
                        mode_next      = MODE_SHALLOW_POS;
                        major_end_next = max_x;
                    end
                    else
                    begin
                        mode_next      = MODE_STEEP_POS;
                        major_end_next = max_y;
                    end
                end
                else if (ady < adx)
                begin
                    mode_next      = MODE_SHALLOW_NEG;
                    cur_x_next     = min_x;
                    cur_y_next     = max_y;
                    major_end_next = max_x;
                end
                else
                begin
                    mode_next      = MODE_STEEP_NEG;
                    cur_x_next     = max_x;
                    cur_y_next     = min_y;
                    major_end_next = max_y;
                end
            end
        end
        else if (res_valid)
        begin
            cur_x_next    = step_x;
            cur_y_next    = step_y;
            decision_next = step_dec;
            first_next    = 1'b0;
            if (step_last)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            decision_reg  <= '0;
            inc_str_reg   <= '0;
            inc_diag_reg  <= '0;
            major_end_reg <= '0;
            mode_reg      <= MODE_HORIZ;
            active_reg    <= 1'b0;
            first_reg     <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            decision_reg  <= decision_next;
            inc_str_reg   <= inc_str_next;
            inc_diag_reg  <= inc_diag_next;
            major_end_reg <= major_end_next;
            mode_reg      <= mode_next;
            active_reg    <= active_next;
            first_reg     <= first_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (res_valid)
        begin
            if (out_free)
            begin
                out_data_reg <= res_data;
            end
            else
            begin
                skid_data_reg <= res_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mplr_checker.sv =====
// ----------------------------------------------------------------------------
// Midpoint line rasterizer port checker
// Watches the core's ports for flow-control and sequencing violations.
// ----------------------------------------------------------------------------
`default_nettype none

module mplr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input mplr_pkg::mplr_in_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input mplr_pkg::mplr_out_t out_data
);
    import mplr_pkg::*;

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result was withdrawn");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_data))
        else $error("stalled result payload changed");

    // The input only stalls when a result is already waiting downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_valid && out_stall))
        else $error("input stalled without a prior output stall");

    // A start transaction never produces a pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.opcode == OP_START && !out_valid) |=> !out_valid)
        else $error("start transaction produced a pixel");

endmodule

bind midpoint_line_rasterizer_core mplr_checker u_mplr_checker (.*);

`default_nettype wire
